FILE: hdl/sqd_pkg.sv
// Shared types and constants for the signed 16.16 fixed-point divider.
package sqd_pkg;

  localparam int WORD_W      = 32;
  localparam int INT_STEPS   = 32;             // one restoring step per integer quotient bit
  localparam int FRAC_W      = 16;             // fraction bits on the small-divisor path
  localparam int SPLIT       = 9;              // quotient bits per large-divisor sub-division
  localparam int FRAC_STEPS  = 2 * SPLIT;
  localparam int PIPE_STAGES = INT_STEPS + FRAC_STEPS;
  localparam int BYTE_SHIFT  = 8;
  localparam int HALF_SHIFT  = 16;

  localparam logic [WORD_W-1:0] BIG_DIVISOR = 32'h0100_0000;

  // One slot of the divider pipeline.
  typedef struct packed {
    logic                  neg;   // operand signs differ
    logic                  dz;    // divisor is zero
    logic                  big;   // divisor magnitude >= BIG_DIVISOR
    logic [WORD_W-1:0]     nb;    // divisor magnitude
    logic [WORD_W-1:0]     p;     // partial remainder
    logic [WORD_W-1:0]     n;     // dividend bits in, integer quotient bits out
    logic [FRAC_W-1:0]     ip;    // low half of the integer quotient
    logic [FRAC_STEPS-1:0] f;     // fraction quotient bits
  } div_stage_t;

endpackage

FILE: hdl/sqd_pipe.sv
// Restoring-division pipeline: one quotient bit per stage, integer then fraction.
module sqd_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  sqd_pkg::div_stage_t in_st,
  output logic               out_vld,
  output sqd_pkg::div_stage_t out_st
);
  import sqd_pkg::*;

  div_stage_t st  [PIPE_STAGES];
  logic       vld [PIPE_STAGES];

  for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_stage
    localparam int J = i - INT_STEPS;

    div_stage_t        prv;
    logic              prv_vld;
    div_stage_t        setup;
    div_stage_t        nxt;
    logic [WORD_W-1:0] dvs;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              qbit;

    if (i == 0) begin : g_first
      assign prv     = in_st;
      assign prv_vld = in_vld;
    end else begin : g_rest
      assign prv     = st[i-1];
      assign prv_vld = vld[i-1];
    end

    always_comb begin
      setup = prv;
      dvs   = prv.nb;
      if (i >= INT_STEPS) begin
        if (prv.big) begin
          // large divisor: rem / (nb>>8), then that remainder / (nb>>16)
          if (J == 0 || J == SPLIT) begin
            setup.p = prv.p >> SPLIT;
            setup.n = {prv.p[SPLIT-1:0], {(WORD_W-SPLIT){1'b0}}};
          end
          dvs = (J < SPLIT) ? (prv.nb >> BYTE_SHIFT) : (prv.nb >> HALF_SHIFT);
        end else if (J == 0) begin
          setup.n = '0;
        end
        if (J == 0) begin
          setup.ip = prv.n[FRAC_W-1:0];
        end
      end

      // partial remainder stays below the divisor, so bit 32 of diff is the borrow
      trial = {setup.p, setup.n[WORD_W-1]};
      diff  = trial - {1'b0, dvs};
      qbit  = ~diff[WORD_W];

      nxt   = setup;
      nxt.p = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      if (i < INT_STEPS) begin
        nxt.n = {setup.n[WORD_W-2:0], qbit};
      end else begin
        nxt.n = {setup.n[WORD_W-2:0], 1'b0};
        if (setup.big || J < FRAC_W) begin
          nxt.f = {setup.f[FRAC_STEPS-2:0], qbit};
        end else begin
          nxt.p = setup.p;      // small path finished, hold
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_vld = vld[PIPE_STAGES-1];
  assign out_st  = st[PIPE_STAGES-1];

endmodule

FILE: hdl/signed_q16_16_divide.sv
// Signed 16.16 fixed-point divider, top level.
// Accepts one dividend/divisor pair every cycle while s_tready is high and
// returns one quotient per pair, in order. Each pair passes through the
// restoring divider, one quotient bit per pipeline stage, 32 integer bits and
// 18 fraction bits, plus an operand stage, a fraction-merge stage, a sign
// stage and the output register. A zero divisor returns quotient 0 with
// tuser set. A two-entry output buffer keeps tready registered; the pipeline
// holds while the buffer is full.
module signed_q16_16_divide (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] dividend, [63:32] divisor
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] quotient
  output logic        m_tuser    // [0] divide_by_zero
);
  import sqd_pkg::*;

  logic                     en;
  logic signed [WORD_W-1:0] dividend;
  logic signed [WORD_W-1:0] divisor;
  logic [WORD_W-1:0]        na;
  logic [WORD_W-1:0]        nb;

  div_stage_t               op_st;
  logic                     op_vld;
  div_stage_t               pipe_st;
  logic                     pipe_vld;

  logic [FRAC_W:0]          frac;
  logic [WORD_W-1:0]        mag;
  logic                     sum_vld;
  logic [WORD_W-1:0]        sum_mag;
  logic                     sum_neg;
  logic                     sum_dz;

  logic                     res_vld;
  logic [WORD_W-1:0]        res_q;
  logic                     res_dz;

  logic                     out_valid;
  logic [WORD_W-1:0]        out_q;
  logic                     out_dz;
  logic                     skid_valid;
  logic [WORD_W-1:0]        skid_q;
  logic                     skid_dz;

  assign en       = ~skid_valid;
  assign s_tready = en;

  assign dividend = s_tdata[WORD_W-1:0];
  assign divisor  = s_tdata[2*WORD_W-1:WORD_W];
  assign na       = dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
  assign nb       = divisor[WORD_W-1]  ? WORD_W'(-divisor)  : divisor;

  // operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
    end else if (en) begin
      op_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_st.neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      op_st.dz  <= (divisor == '0);
      op_st.big <= (nb >= BIG_DIVISOR);
      op_st.nb  <= nb;
      op_st.p   <= '0;
      op_st.n   <= na;
      op_st.ip  <= '0;
      op_st.f   <= '0;
    end
  end

  sqd_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (op_vld),
    .in_st   (op_st),
    .out_vld (pipe_vld),
    .out_st  (pipe_st)
  );

  // merge the fraction bits: (qa << 8) + qb on the large path
  always_comb begin
    if (pipe_st.big) begin
      frac = {pipe_st.f[FRAC_STEPS-1:SPLIT], {BYTE_SHIFT{1'b0}}}
           + {{(FRAC_W+1-SPLIT){1'b0}}, pipe_st.f[SPLIT-1:0]};
    end else begin
      frac = {1'b0, pipe_st.f[FRAC_W-1:0]};
    end
    mag = {pipe_st.ip, {FRAC_W{1'b0}}} + {{(WORD_W-FRAC_W-1){1'b0}}, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
      res_vld <= 1'b0;
    end else if (en) begin
      sum_vld <= pipe_vld;
      res_vld <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_mag <= mag;
      sum_neg <= pipe_st.neg;
      sum_dz  <= pipe_st.dz;
      res_dz  <= sum_dz;
      if (sum_dz) begin
        res_q <= '0;
      end else if (sum_neg) begin
        res_q <= WORD_W'(-sum_mag);
      end else begin
        res_q <= sum_mag;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= res_vld;
      end
    end else if (res_vld && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_q  <= skid_q;
        out_dz <= skid_dz;
      end else begin
        out_q  <= res_q;
        out_dz <= res_dz;
      end
    end else if (res_vld && en) begin
      skid_q  <= res_q;
      skid_dz <= res_dz;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;
  assign m_tuser  = out_dz;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && res_vld && en) |=> skid_valid)
    else $error("result arriving at a stalled output was not parked");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("zero-divisor result carries a nonzero quotient");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !(out_valid && m_tready)) |=> skid_valid)
    else $error("skid entry dropped without an output transfer");

endmodule
